// ===== design/isng_pkg.sv =====
// ----------------------------------------------------------------------------
// isng_pkg
// Shared types and constants of the Ising Metropolis spin-update block.
// ----------------------------------------------------------------------------
package isng_pkg;

  localparam int DefSide = 32;
  localparam int CoordW  = 5;
  localparam int FracW   = 16;
  localparam int DeW     = 5;
  localparam int EnergyW = 13;
  localparam int MagW    = 12;
  localparam int QDepth  = 2;

  localparam logic [FracW-1:0] ResetDe4 = 16'd29446;
  localparam logic [FracW-1:0] ResetDe8 = 16'd13231;

  typedef enum logic [0:0] {
    CMD_TRIAL = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_DE4 = 1'b0,
    CFG_DE8 = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_CENTRE,
    BK_EXEC
  } bk_state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic             spin_value;
    logic [FracW-1:0] rnd;
  } op_t;

  typedef struct packed {
    logic                      spin_now;
    logic                      flipped;
    logic signed [DeW-1:0]     de;
    logic signed [EnergyW-1:0] energy;
    logic signed [MagW-1:0]    mag;
  } res_t;

endpackage

// ===== design/isng_front.sv =====
// ----------------------------------------------------------------------------
// isng_front
// Takes items in, wraps the site onto the lattice, works out the four
// neighbour coordinates and holds the decoded items in a short queue.
// ----------------------------------------------------------------------------
module isng_front
  import isng_pkg::*;
#(
  parameter int Side = DefSide,
  localparam int IdxW = $clog2(Side)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic              init_busy_i,
  input  logic              cmd_i,
  input  logic [CoordW-1:0] row_i,
  input  logic [CoordW-1:0] col_i,
  input  logic              spin_value_i,
  input  logic [FracW-1:0]  random_fraction_i,
  output logic              hd_valid_o,
  input  logic              hd_pop_i,
  output op_t               hd_op_o,
  output logic [IdxW-1:0]   hd_row_o,
  output logic [IdxW-1:0]   hd_row_up_o,
  output logic [IdxW-1:0]   hd_row_dn_o,
  output logic [IdxW-1:0]   hd_col_o,
  output logic [IdxW-1:0]   hd_col_lt_o,
  output logic [IdxW-1:0]   hd_col_rt_o
);

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;

  op_t             op_mem    [QDepth];
  logic [IdxW-1:0] row_mem   [QDepth];
  logic [IdxW-1:0] row_up_mem[QDepth];
  logic [IdxW-1:0] row_dn_mem[QDepth];
  logic [IdxW-1:0] col_mem   [QDepth];
  logic [IdxW-1:0] col_lt_mem[QDepth];
  logic [IdxW-1:0] col_rt_mem[QDepth];

  logic [IdxW-1:0] row_w, col_w;
  op_t             op_w;

  // coordinates arrive 5 bits wide, fold them onto the Side-wide lattice
  function automatic logic [IdxW-1:0] wrap_coord(logic [CoordW-1:0] v);
    logic [CoordW-1:0] t;
    t = v;
    for (int k = 0; k < 8; k++) begin
      if (int'(t) >= Side) begin
        t = CoordW'(int'(t) - Side);
      end
    end
    return IdxW'(t);
  endfunction

  function automatic logic [IdxW-1:0] prev_coord(logic [IdxW-1:0] x);
    return (x == '0) ? IdxW'(Side - 1) : x - 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] next_coord(logic [IdxW-1:0] x);
    return (x == IdxW'(Side - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(QDepth)) || init_busy_i;
  assign do_push = push_i && !full_o;

  always_comb begin
    row_w         = wrap_coord(row_i);
    col_w         = wrap_coord(col_i);
    op_w.cmd      = cmd_e'(cmd_i);
    op_w.spin_value = spin_value_i;
    op_w.rnd      = random_fraction_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = ptr_inc(wr_ptr_q);
    end
    if (hd_pop_i) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
    end
    case ({do_push, hd_pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      op_mem[wr_ptr_q]     <= op_w;
      row_mem[wr_ptr_q]    <= row_w;
      row_up_mem[wr_ptr_q] <= prev_coord(row_w);
      row_dn_mem[wr_ptr_q] <= next_coord(row_w);
      col_mem[wr_ptr_q]    <= col_w;
      col_lt_mem[wr_ptr_q] <= prev_coord(col_w);
      col_rt_mem[wr_ptr_q] <= next_coord(col_w);
    end
  end

  assign hd_valid_o  = (cnt_q != '0);
  assign hd_op_o     = op_mem[rd_ptr_q];
  assign hd_row_o    = row_mem[rd_ptr_q];
  assign hd_row_up_o = row_up_mem[rd_ptr_q];
  assign hd_row_dn_o = row_dn_mem[rd_ptr_q];
  assign hd_col_o    = col_mem[rd_ptr_q];
  assign hd_col_lt_o = col_lt_mem[rd_ptr_q];
  assign hd_col_rt_o = col_rt_mem[rd_ptr_q];

endmodule

// ===== design/isng_back.sv =====
// ----------------------------------------------------------------------------
// isng_back
// Holds the spin lattice (one row per memory word), the running totals and
// the acceptance thresholds, and carries out one trial or write at a time.
// ----------------------------------------------------------------------------
module isng_back
  import isng_pkg::*;
#(
  parameter int Side = DefSide,
  localparam int IdxW = $clog2(Side)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [FracW-1:0] cfg_data_i,
  output logic             init_busy_o,
  input  logic             hd_valid_i,
  output logic             hd_pop_o,
  input  op_t              hd_op_i,
  input  logic [IdxW-1:0]  hd_row_i,
  input  logic [IdxW-1:0]  hd_row_up_i,
  input  logic [IdxW-1:0]  hd_row_dn_i,
  input  logic [IdxW-1:0]  hd_col_i,
  input  logic [IdxW-1:0]  hd_col_lt_i,
  input  logic [IdxW-1:0]  hd_col_rt_i,
  input  logic             res_full_i,
  output logic             res_push_o,
  output res_t             res_o
);

  localparam logic [MagW-1:0]    MagRst    = MagW'(Side * Side);
  localparam logic [EnergyW-1:0] EnergyRst = EnergyW'(-2 * Side * Side);

  bk_state_e state_q, state_d;
  logic [IdxW-1:0] clr_cnt_q, clr_cnt_d;

  logic [FracW-1:0]   th4_q, th4_d, th8_q, th8_d;
  logic [EnergyW-1:0] energy_q, energy_d;
  logic [MagW-1:0]    mag_q, mag_d;

  // item held while it is worked on
  op_t             op_q;
  logic [IdxW-1:0] row_q, col_q, col_lt_q, col_rt_q;
  logic            up_q, dn_q;

  // lattice memory, two read ports and one write port
  logic [Side-1:0] lat_mem [Side];
  logic [Side-1:0] rd_a_q, rd_b_q, mem_wdata;
  logic [IdxW-1:0] rd_a_addr, rd_b_addr, mem_waddr;
  logic            mem_we;

  logic            own, lt, rt, take;
  logic [2:0]      n_same;
  logic [DeW-1:0]  de_raw, de_applied;
  logic [Side-1:0] exec_row;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lat_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= lat_mem[rd_a_addr];
    rd_b_q <= lat_mem[rd_b_addr];
  end

  // update of the addressed site from the centre row and neighbour bits
  always_comb begin
    own    = rd_a_q[col_q];
    lt     = rd_a_q[col_lt_q];
    rt     = rd_a_q[col_rt_q];
    n_same = 3'(up_q == own) + 3'(dn_q == own) + 3'(lt == own) + 3'(rt == own);
    // dE = 4 * (aligned neighbours) - 8
    de_raw = DeW'({n_same, 2'b00}) - DeW'(8);
    case (op_q.cmd)
      CMD_TRIAL: begin
        if (n_same <= 3'd2) begin
          take = 1'b1;
        end else if (n_same == 3'd3) begin
          take = th4_q > op_q.rnd;
        end else begin
          take = th8_q > op_q.rnd;
        end
      end
      CMD_WRITE: take = op_q.spin_value != own;
      default:   take = 1'b0;
    endcase
    de_applied = take ? de_raw : '0;
    energy_d   = energy_q + {{(EnergyW-DeW){de_applied[DeW-1]}}, de_applied};
    if (!take) begin
      mag_d = mag_q;
    end else if (own) begin
      mag_d = mag_q - MagW'(2);
    end else begin
      mag_d = mag_q + MagW'(2);
    end
    exec_row = rd_a_q ^ (Side'(take) << col_q);
  end

  always_comb begin
    res_o.spin_now = own ^ take;
    res_o.flipped  = take;
    res_o.de       = de_applied;
    res_o.energy   = energy_d;
    res_o.mag      = mag_d;
  end

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    hd_pop_o   = 1'b0;
    res_push_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = row_q;
    mem_wdata  = exec_row;
    rd_a_addr  = row_q;
    rd_b_addr  = row_q;
    case (state_q)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == IdxW'(Side - 1)) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        rd_a_addr = hd_row_up_i;
        rd_b_addr = hd_row_dn_i;
        if (hd_valid_i && !res_full_i) begin
          hd_pop_o = 1'b1;
          state_d  = BK_CENTRE;
        end
      end
      BK_CENTRE: begin
        rd_a_addr = row_q;
        state_d   = BK_EXEC;
      end
      BK_EXEC: begin
        mem_we     = 1'b1;
        res_push_o = 1'b1;
        state_d    = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    th4_d = th4_q;
    th8_d = th8_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_DE4: th4_d = cfg_data_i;
        CFG_DE8: th8_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      clr_cnt_q <= '0;
      th4_q     <= ResetDe4;
      th8_q     <= ResetDe8;
      energy_q  <= EnergyRst;
      mag_q     <= MagRst;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      th4_q     <= th4_d;
      th8_q     <= th8_d;
      if (state_q == BK_EXEC) begin
        energy_q <= energy_d;
        mag_q    <= mag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hd_pop_o) begin
      op_q     <= hd_op_i;
      row_q    <= hd_row_i;
      col_q    <= hd_col_i;
      col_lt_q <= hd_col_lt_i;
      col_rt_q <= hd_col_rt_i;
    end
    // neighbour rows were read while idle, keep only the bits needed
    if (state_q == BK_CENTRE) begin
      up_q <= rd_a_q[col_q];
      dn_q <= rd_b_q[col_q];
    end
  end

  assign init_busy_o = (state_q == BK_CLEAR);

  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hd_pop_o |-> hd_valid_i && !res_full_i)
    else $error("item taken from empty queue or with no result room");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_totals_only_on_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mag_q != $past(mag_q)) |-> ($past(state_q) == BK_EXEC))
    else $error("magnetisation moved outside an update");

  a_clear_covers_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_CLEAR) ##1 (state_q != BK_CLEAR)
      |-> ($past(clr_cnt_q) == IdxW'(Side - 1)))
    else $error("lattice initialisation ended early");

endmodule

// ===== design/isng_res_fifo.sv =====
// ----------------------------------------------------------------------------
// isng_res_fifo
// Short queue of finished results between the update engine and the output.
// ----------------------------------------------------------------------------
module isng_res_fifo
  import isng_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t data_o
);

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  res_t            mem [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_ptr_q];

  always_comb begin
    case ({push_i, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/ising_metropolis_spin_update.sv =====
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// Metropolis spin-update engine for a wrapped square Ising lattice.
// ----------------------------------------------------------------------------
// Each item passes through the engine's idle, centre and exec states: the rows
// above and below the site are read on the two read ports of the row-wide
// lattice memory, then the site's own row is read, then the spin, energy and
// magnetisation are updated and the result is queued; the single memory write
// port and the order of those reads set that sequence. An item pushed into an
// idle block goes through the input queue, these states and the result queue.
// Two-entry queues on the input and result sides let items arrive and results
// wait independently. After reset the lattice is set to all spins up one row
// per cycle, during which full stays high; threshold writes are taken at any time.
module ising_metropolis_spin_update
  import isng_pkg::*;
#(
  parameter int Side = DefSide
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [FracW-1:0]          cfg_data_i,
  input  logic                      push,
  output logic                      full,
  input  logic                      cmd_i,
  input  logic [CoordW-1:0]         row_i,
  input  logic [CoordW-1:0]         col_i,
  input  logic                      spin_value_i,
  input  logic [FracW-1:0]          random_fraction_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      spin_now_o,
  output logic                      flipped_o,
  output logic signed [DeW-1:0]     energy_change_o,
  output logic signed [EnergyW-1:0] total_energy_o,
  output logic signed [MagW-1:0]    net_magnetization_o
);

  localparam int IdxW = $clog2(Side);

  logic            init_busy, hd_valid, hd_pop, res_full, res_push;
  op_t             hd_op;
  logic [IdxW-1:0] hd_row, hd_row_up, hd_row_dn, hd_col, hd_col_lt, hd_col_rt;
  res_t            res_in, res_out;

  isng_front #(
    .Side(Side)
  ) u_front (
    .clk_i,
    .rst_ni,
    .push_i            (push),
    .full_o            (full),
    .init_busy_i       (init_busy),
    .cmd_i,
    .row_i,
    .col_i,
    .spin_value_i,
    .random_fraction_i,
    .hd_valid_o        (hd_valid),
    .hd_pop_i          (hd_pop),
    .hd_op_o           (hd_op),
    .hd_row_o          (hd_row),
    .hd_row_up_o       (hd_row_up),
    .hd_row_dn_o       (hd_row_dn),
    .hd_col_o          (hd_col),
    .hd_col_lt_o       (hd_col_lt),
    .hd_col_rt_o       (hd_col_rt)
  );

  isng_back #(
    .Side(Side)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .init_busy_o (init_busy),
    .hd_valid_i  (hd_valid),
    .hd_pop_o    (hd_pop),
    .hd_op_i     (hd_op),
    .hd_row_i    (hd_row),
    .hd_row_up_i (hd_row_up),
    .hd_row_dn_i (hd_row_dn),
    .hd_col_i    (hd_col),
    .hd_col_lt_i (hd_col_lt),
    .hd_col_rt_i (hd_col_rt),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  isng_res_fifo u_res_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign spin_now_o          = res_out.spin_now;
  assign flipped_o           = res_out.flipped;
  assign energy_change_o     = res_out.de;
  assign total_energy_o      = res_out.energy;
  assign net_magnetization_o = res_out.mag;

endmodule
